FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Types, constants and rounding helper for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  // four doubled products plus the constant one need four guard bits
  localparam int ACC_W      = 2 * DATA_WIDTH + 4;

  localparam logic signed [ACC_W-1:0] ACC_UNIT = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_UNIT << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_UNIT << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] VAL_MAX  =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] VAL_MIN  = ~VAL_MAX;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_CONJ   = 3'd3,
    OP_DOT    = 3'd4,
    OP_SCALE  = 3'd5,
    OP_MATRIX = 3'd6
  } op_t;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_MID   = 2'd1;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         clip;
  } sat_t;

  // round half up from 2^-2F units to 2^-F units, then clip to the word
  function automatic sat_t round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    sat_t                    rv;
    r = (s + ACC_HALF) >>> FRAC_BITS;
    if (r > VAL_MAX) begin
      rv.value = VAL_MAX[DATA_WIDTH-1:0];
      rv.clip  = 1'b1;
    end else if (r < VAL_MIN) begin
      rv.value = VAL_MIN[DATA_WIDTH-1:0];
      rv.clip  = 1'b1;
    end else begin
      rv.value = r[DATA_WIDTH-1:0];
      rv.clip  = 1'b0;
    end
    return rv;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qau_cmd_if.sv
// ----------------------------------------------------------------------------
// qau_cmd_if
// Input channel: operation code and two quaternions per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qau_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            operation;
  logic signed [qau_pkg::DATA_WIDTH-1:0] a_r;
  logic signed [qau_pkg::DATA_WIDTH-1:0] a_i;
  logic signed [qau_pkg::DATA_WIDTH-1:0] a_j;
  logic signed [qau_pkg::DATA_WIDTH-1:0] a_k;
  logic signed [qau_pkg::DATA_WIDTH-1:0] b_r;
  logic signed [qau_pkg::DATA_WIDTH-1:0] b_i;
  logic signed [qau_pkg::DATA_WIDTH-1:0] b_j;
  logic signed [qau_pkg::DATA_WIDTH-1:0] b_k;

  modport source (
    output valid, operation, a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k,
    input  ready
  );
  modport sink (
    input  valid, operation, a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/qau_res_if.sv
// ----------------------------------------------------------------------------
// qau_res_if
// Result channel: four values plus last and saturation flags per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qau_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qau_pkg::DATA_WIDTH-1:0] value_0;
  logic signed [qau_pkg::DATA_WIDTH-1:0] value_1;
  logic signed [qau_pkg::DATA_WIDTH-1:0] value_2;
  logic signed [qau_pkg::DATA_WIDTH-1:0] value_3;
  logic                                  last;
  logic                                  saturated;

  modport source (
    output valid, value_0, value_1, value_2, value_3, last, saturated,
    input  ready
  );
  modport sink (
    input  valid, value_0, value_1, value_2, value_3, last, saturated,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/quaternion_arithmetic_unit_core.sv
// A result beat passes through the input register, the product register and the output register.
// Throughput: one input beat per cycle while the output is not stalled; the rotation matrix op
// holds the product stage for its three rows, one row per cycle while the output takes them.
// All sixteen products come from one 4x4 multiplier array in a single pass.
// Reset (rst, synchronous) empties all three stages; the data registers keep their contents.
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Fixed-point quaternion ALU: input register, product register, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quaternion_arithmetic_unit_core (
  input  wire            clk,
  input  wire            rst,
  qau_cmd_if.sink        cmd,
  qau_res_if.source      res
);

  localparam int DW  = qau_pkg::DATA_WIDTH;
  localparam int PW  = qau_pkg::PROD_W;
  localparam int AW  = qau_pkg::ACC_W;
  localparam int FB  = qau_pkg::FRAC_BITS;

  // ---------------- stage 1: input register ----------------
  logic                 s1_valid;
  qau_pkg::op_t         s1_op;
  logic signed [DW-1:0] s1_a [4];
  logic signed [DW-1:0] s1_b [4];

  // ---------------- stage 2: product register ----------------
  logic                 s2_valid;
  qau_pkg::op_t         s2_op;
  logic signed [DW-1:0] s2_a [4];
  logic signed [DW-1:0] s2_b [4];
  logic signed [PW-1:0] s2_prod [4][4];
  logic [1:0]           row;

  // ---------------- stage 3: output register ----------------
  logic                 out_valid;
  logic signed [DW-1:0] out_value [4];
  logic                 out_last;
  logic                 out_sat;

  // flow control
  logic out_free, s2_fire, s2_last, s2_free, s1_fire, s1_free, cmd_fire;
  logic s2_matrix;

  assign out_free  = !out_valid || res.ready;
  assign s2_fire   = s2_valid && out_free;
  assign s2_last   = (s2_op != qau_pkg::OP_MATRIX) || (row == qau_pkg::ROW_LAST);
  assign s2_free   = !s2_valid || (s2_fire && s2_last);
  assign s1_fire   = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s1_fire;
  assign s2_matrix = s2_valid && (s2_op == qau_pkg::OP_MATRIX);

  // no beat is taken while in reset
  assign cmd.ready = s1_free && !rst;
  assign cmd_fire  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_fire || (s1_valid && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_op   <= qau_pkg::op_t'(cmd.operation);
      s1_a[0] <= cmd.a_r;
      s1_a[1] <= cmd.a_i;
      s1_a[2] <= cmd.a_j;
      s1_a[3] <= cmd.a_k;
      s1_b[0] <= cmd.b_r;
      s1_b[1] <= cmd.b_i;
      s1_b[2] <= cmd.b_j;
      s1_b[3] <= cmd.b_k;
    end
  end

  // outer product a x m, where m is b, or a itself for the rotation matrix
  logic signed [DW-1:0] mul_m [4];
  logic signed [PW-1:0] prod_next [4][4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mul_m[j] = (s1_op == qau_pkg::OP_MATRIX) ? s1_a[j] : s1_b[j];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_next[i][j] = PW'(s1_a[i]) * PW'(mul_m[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      row      <= qau_pkg::ROW_FIRST;
    end else begin
      s2_valid <= s1_fire || (s2_valid && !(s2_fire && s2_last));
      if (s2_fire) begin
        row <= s2_last ? qau_pkg::ROW_FIRST : row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_op   <= s1_op;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_prod <= prod_next;
    end
  end

  // sums in 2^-2F units, then round and clip per lane
  logic signed [AW-1:0] pe  [4][4];
  logic signed [AW-1:0] ash [4];
  logic signed [AW-1:0] bsh [4];
  logic signed [AW-1:0] acc [4];
  qau_pkg::sat_t        rs  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = AW'(s2_prod[i][j]);
      end
      ash[i] = AW'(s2_a[i]) <<< FB;
      bsh[i] = AW'(s2_b[i]) <<< FB;
      acc[i] = '0;
    end

    case (s2_op)
      qau_pkg::OP_MUL: begin
        acc[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
        acc[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
        acc[2] = pe[0][2] + pe[2][0] + pe[3][1] - pe[1][3];
        acc[3] = pe[0][3] + pe[3][0] + pe[1][2] - pe[2][1];
      end
      qau_pkg::OP_ADD: begin
        for (int c = 0; c < 4; c++) acc[c] = ash[c] + bsh[c];
      end
      qau_pkg::OP_SUB: begin
        for (int c = 0; c < 4; c++) acc[c] = ash[c] - bsh[c];
      end
      qau_pkg::OP_CONJ: begin
        acc[0] = ash[0];
        for (int c = 1; c < 4; c++) acc[c] = -ash[c];
      end
      qau_pkg::OP_DOT: begin
        acc[0] = pe[0][0] + pe[1][1] + pe[2][2] + pe[3][3];
      end
      qau_pkg::OP_SCALE: begin
        for (int c = 0; c < 4; c++) acc[c] = pe[c][0];
      end
      qau_pkg::OP_MATRIX: begin
        // w=0 x=1 y=2 z=3, products are a_i*a_j
        case (row)
          qau_pkg::ROW_FIRST: begin
            acc[0] = qau_pkg::ACC_ONE - ((pe[2][2] + pe[3][3]) <<< 1);
            acc[1] = (pe[1][2] - pe[0][3]) <<< 1;
            acc[2] = (pe[1][3] + pe[0][2]) <<< 1;
          end
          qau_pkg::ROW_MID: begin
            acc[0] = (pe[1][2] + pe[0][3]) <<< 1;
            acc[1] = qau_pkg::ACC_ONE - ((pe[1][1] + pe[3][3]) <<< 1);
            acc[2] = (pe[2][3] - pe[0][1]) <<< 1;
          end
          default: begin
            acc[0] = (pe[1][3] - pe[0][2]) <<< 1;
            acc[1] = (pe[2][3] + pe[0][1]) <<< 1;
            acc[2] = qau_pkg::ACC_ONE - ((pe[1][1] + pe[2][2]) <<< 1);
          end
        endcase
      end
      default: begin
        // undefined code: zeros
      end
    endcase

    for (int c = 0; c < 4; c++) begin
      rs[c] = qau_pkg::round_sat(acc[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_fire || (out_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      for (int c = 0; c < 4; c++) out_value[c] <= rs[c].value;
      out_last <= s2_last;
      out_sat  <= rs[0].clip | rs[1].clip | rs[2].clip | rs[3].clip;
    end
  end

  assign res.valid     = out_valid;
  assign res.value_0   = out_value[0];
  assign res.value_1   = out_value[1];
  assign res.value_2   = out_value[2];
  assign res.value_3   = out_value[3];
  assign res.last      = out_last;
  assign res.saturated = out_sat;

  // a row count past the first only while a matrix item sits in the product stage
  `ASSERT_CLK(a_row_matrix, (row != qau_pkg::ROW_FIRST) |-> s2_matrix, "row moved off matrix")
  // a non-final beat means the rest of that matrix is still held behind it
  `ASSERT_CLK(a_open_run, (out_valid && !out_last) |-> s2_matrix, "open run, no matrix rows")
  // the product stage never takes a new item while a matrix is mid-run
  `ASSERT_NEVER(a_no_overwrite, s1_fire && s2_valid && !s2_last, "matrix run overwritten")

endmodule

`default_nettype wire
